[rtl/cpbd_pkg.sv]
// Shared types, constants and helper functions of the column percentile byte dequantizer.
`timescale 1ns / 1ps

package cpbd_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int SIZE_W      = 11;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 11'd1024;

  localparam int QDEPTH = 2;
  localparam int Q_AW   = 1;
  localparam int Q_CW   = 2;

  localparam int CFG_DATA_W = 32;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_DATA   = 1'b1;

  localparam logic [7:0] SEG_LOW_TOP = 8'd64;
  localparam logic [7:0] SEG_MID_TOP = 8'd192;

  typedef enum logic [1:0] {
    CFG_BASE_VALUE,
    CFG_VALUE_RANGE,
    CFG_ROW_COUNT,
    CFG_COL_COUNT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_MID,
    SEG_HIGH
  } seg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_FOLD,
    BK_MERGE,
    BK_PCT,
    BK_DIFF,
    BK_ABS,
    BK_SCALE,
    BK_DIV,
    BK_SUM,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] base_value;
    logic [30:0]        value_range;
    logic [10:0]        row_count;
    logic [10:0]        col_count;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] pct0_code;
    logic [15:0] pct25_code;
    logic [15:0] pct75_code;
    logic [15:0] pct100_code;
    logic [7:0]  code;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        code;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              last;
    logic [15:0]       q0;
    logic [15:0]       q25;
    logic [15:0]       q75;
    logic [15:0]       q100;
  } job_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    if (v > SIZE_LIMIT) r = SIZE_LIMIT;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [31:0] r;
    if (x > 42'sd2147483647) r = 32'sh7fffffff;
    else if (x < -42'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[rtl/column_percentile_byte_dequantizer.sv]
// Top level of the column percentile byte dequantizer.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   in_item_t
//   result   out        result_valid / result_stall  out_item_t
//   cfg      in         cfg_write                 cfg_index, cfg_data
//
// A header transaction yields no result.
// A data byte runs through the back-end states MUL, FOLD, MERGE and PCT twice, then
// DIFF, ABS, SCALE, DIV, SUM and EMIT, before it reaches the result register: the two
// percentile conversions share one multiplier, and the divide by 63 folds six bits
// a cycle. Reset is synchronous; it clears positions and the store fill count, and
// store entries past the fill count read as zero. item_stall rises when the front
// stage holds a byte and the queue is full; a result holds until taken.
`timescale 1ns / 1ps

module column_percentile_byte_dequantizer import cpbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  cfg_write,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic push;
  job_t push_data;
  logic full;
  logic pop;
  logic q_valid;
  job_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_value  <= 32'sd0;
      cfg.value_range <= 31'd65536;
      cfg.row_count   <= 11'd1;
      cfg.col_count   <= 11'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BASE_VALUE:  cfg.base_value  <= cfg_data;
        CFG_VALUE_RANGE: cfg.value_range <= cfg_data[30:0];
        CFG_ROW_COUNT:   cfg.row_count   <= cfg_data[10:0];
        CFG_COL_COUNT:   cfg.col_count   <= cfg_data[10:0];
      endcase
    end
  end

  cpbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cpbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  cpbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

[rtl/cpbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/cpbd_front.sv]
// Front end: accepts transactions, stores column headers, tracks position, reads the store.
`timescale 1ns / 1ps

module cpbd_front import cpbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  output logic     push,
  output job_t     push_data,
  input  logic     full
);

  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nc;
  logic [SIZE_W-1:0] headers_loaded;
  logic [SIZE_W-1:0] fill;
  logic [ADDR_W-1:0] row_pos;
  logic [ADDR_W-1:0] col_pos;
  logic              accept;
  logic              hdr_wr;
  logic              data_acc;
  logic              row_end;
  logic              col_end;
  logic [63:0]       rdata;

  logic              s1_valid;
  logic [7:0]        s1_code;
  logic [ADDR_W-1:0] s1_row;
  logic [ADDR_W-1:0] s1_col;
  logic              s1_last;
  logic              s1_hit;

  assign nr         = eff_size(cfg.row_count);
  assign nc         = eff_size(cfg.col_count);
  assign item_stall = s1_valid & full;
  assign push       = s1_valid & ~full;
  assign accept     = item_valid & ~item_stall;
  assign hdr_wr     = accept & (item.func == FUNC_HEADER) & (headers_loaded < nc);
  assign data_acc   = accept & (item.func == FUNC_DATA);
  assign row_end    = ({1'b0, row_pos} + SIZE_W'(1)) >= nr;
  assign col_end    = ({1'b0, col_pos} + SIZE_W'(1)) >= nc;

  cpbd_ram #(
    .WIDTH(64),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (hdr_wr),
    .waddr(headers_loaded[ADDR_W-1:0]),
    .wdata({item.pct0_code, item.pct25_code, item.pct75_code, item.pct100_code}),
    .re   (data_acc),
    .raddr(col_pos),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      headers_loaded <= '0;
      fill           <= '0;
      row_pos        <= '0;
      col_pos        <= '0;
    end else begin
      if (data_acc) s1_valid <= 1'b1;
      else if (push) s1_valid <= 1'b0;
      if (hdr_wr) begin
        headers_loaded <= headers_loaded + SIZE_W'(1);
        if (headers_loaded >= fill) fill <= headers_loaded + SIZE_W'(1);
      end
      if (data_acc) begin
        if (row_end) begin
          row_pos <= '0;
          if (col_end) begin
            col_pos        <= '0;
            headers_loaded <= '0;
          end else begin
            col_pos <= col_pos + ADDR_W'(1);
          end
        end else begin
          row_pos <= row_pos + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_code <= item.code;
      s1_row  <= row_pos;
      s1_col  <= col_pos;
      s1_last <= row_end & col_end;
      s1_hit  <= {1'b0, col_pos} < fill;
    end
  end

  // entries past the fill count were never written and read as zero
  always_comb begin
    push_data.code = s1_code;
    push_data.row  = s1_row;
    push_data.col  = s1_col;
    push_data.last = s1_last;
    push_data.q0   = s1_hit ? rdata[63:48] : 16'd0;
    push_data.q25  = s1_hit ? rdata[47:32] : 16'd0;
    push_data.q75  = s1_hit ? rdata[31:16] : 16'd0;
    push_data.q100 = s1_hit ? rdata[15:0]  : 16'd0;
  end

endmodule

[rtl/cpbd_queue.sv]
// Short queue between front end and back end.
`timescale 1ns / 1ps

module cpbd_queue import cpbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_data
);

  job_t            entries [QDEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full    = count == Q_CW'(QDEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop) rd_ptr <= rd_ptr + Q_AW'(1);
      if (push && !pop) count <= count + Q_CW'(1);
      else if (pop && !push) count <= count - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

[rtl/cpbd_back.sv]
// Back end: percentile conversion, piecewise interpolation and result register.
`timescale 1ns / 1ps

module cpbd_back import cpbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  back_state_t        state;
  back_state_t        state_next;
  logic               out_load;

  job_t               job;
  seg_t               seg;
  logic [7:0]         steps;
  logic [15:0]        pc_lo;
  logic [15:0]        pc_hi;
  logic               pass_hi;
  logic [46:0]        prod;
  logic [30:0]        h;
  logic [31:0]        s;
  logic [31:0]        hq;
  logic [16:0]        t;
  logic signed [31:0] plo;
  logic signed [31:0] phi;
  logic signed [32:0] d;
  logic               neg;
  logic [31:0]        mag;
  logic [39:0]        m;
  logic [33:0]        quo;
  logic signed [31:0] res;
  logic signed [41:0] pct_sum;
  logic signed [41:0] out_sum;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid) state_next = BK_MUL;
      BK_MUL:   state_next = BK_FOLD;
      BK_FOLD:  state_next = BK_MERGE;
      BK_MERGE: state_next = BK_PCT;
      BK_PCT:   state_next = pass_hi ? BK_DIFF : BK_MUL;
      BK_DIFF:  state_next = BK_ABS;
      BK_ABS:   state_next = BK_SCALE;
      BK_SCALE: state_next = BK_DIV;
      BK_DIV:   if (seg != SEG_HIGH || m[39:6] == '0) state_next = BK_SUM;
      BK_SUM:   state_next = BK_EMIT;
      BK_EMIT:  if (out_load) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_EMIT: out_load = ~result_valid | ~result_stall;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign pct_sum = $signed({{10{cfg.base_value[31]}}, cfg.base_value})
                 + $signed({10'd0, hq}) + $signed({41'd0, t >= 17'd65535});
  assign out_sum = neg ? $signed({{10{plo[31]}}, plo}) - $signed({8'd0, quo})
                       : $signed({{10{plo[31]}}, plo}) + $signed({8'd0, quo});

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        job     <= q_data;
        pass_hi <= 1'b0;
        if (q_data.code <= SEG_LOW_TOP) begin
          seg   <= SEG_LOW;
          steps <= q_data.code;
          pc_lo <= q_data.q0;
          pc_hi <= q_data.q25;
        end else if (q_data.code <= SEG_MID_TOP) begin
          seg   <= SEG_MID;
          steps <= q_data.code - SEG_LOW_TOP;
          pc_lo <= q_data.q25;
          pc_hi <= q_data.q75;
        end else begin
          seg   <= SEG_HIGH;
          steps <= q_data.code - SEG_MID_TOP;
          pc_lo <= q_data.q75;
          pc_hi <= q_data.q100;
        end
      end
      BK_MUL: prod <= {16'd0, cfg.value_range} * {31'd0, (pass_hi ? pc_hi : pc_lo)};
      // fold the product twice to divide by 65535
      BK_FOLD: begin
        h <= prod[46:16];
        s <= {1'b0, prod[46:16]} + {16'd0, prod[15:0]};
      end
      BK_MERGE: begin
        hq <= {1'b0, h} + {16'd0, s[31:16]};
        t  <= {1'b0, s[31:16]} + {1'b0, s[15:0]};
      end
      BK_PCT: begin
        if (pass_hi) phi <= sat32(pct_sum);
        else plo <= sat32(pct_sum);
        pass_hi <= 1'b1;
      end
      BK_DIFF: d <= {phi[31], phi} - {plo[31], plo};
      BK_ABS: begin
        neg <= d[32];
        mag <= d[32] ? 32'(-d) : d[31:0];
      end
      BK_SCALE: begin
        m   <= {8'd0, mag} * {32'd0, steps};
        quo <= '0;
      end
      BK_DIV: begin
        unique case (seg)
          SEG_LOW: quo <= m[39:6];
          SEG_MID: quo <= {1'b0, m[39:7]};
          SEG_HIGH: begin
            // fold six bits a step to divide by 63
            if (m[39:6] != '0) begin
              quo <= quo + m[39:6];
              m   <= {6'd0, m[39:6]} + {34'd0, m[5:0]};
            end else if (m[5:0] == 6'd63) begin
              quo <= quo + 34'd1;
            end
          end
          default: quo <= quo;
        endcase
      end
      BK_SUM: res <= sat32(out_sum);
      default: res <= res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (out_load) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.sample_value <= res;
      result.out_row      <= job.row;
      result.out_col      <= job.col;
      result.last         <= job.last;
    end
  end

endmodule

[rtl/cpbd_checker.sv]
// Port-level checker of the column percentile byte dequantizer and its bind.
`timescale 1ns / 1ps

module cpbd_checker import cpbd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("handshake active after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> $past(item_valid && !item_stall) || $past(item_stall))
    else $error("stall raised without a held transaction");

endmodule

bind column_percentile_byte_dequantizer cpbd_checker u_checker (.*);
